// File: rtl/core/bra_pkg.sv
// shared types and constants for the banker's resource allocator
package bra_pkg;

   localparam int MAX_CLIENTS_DEF   = 16;
   localparam int NUM_RESOURCES_DEF = 4;
   localparam int NUM_INIT_REGS     = 4;

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_CLOSE   = 2'd2;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   localparam logic [2:0] STS_ACK       = 3'd0;
   localparam logic [2:0] STS_WAIT      = 3'd1;
   localparam logic [2:0] STS_NO_CLIENT = 3'd2;
   localparam logic [2:0] STS_OVER_REL  = 3'd3;
   localparam logic [2:0] STS_HOLDING   = 3'd4;
   localparam logic [2:0] STS_DUPLICATE = 3'd5;

   localparam logic [2:0] REG_RES_IN_USE = 3'd0;
   localparam logic [2:0] REG_INIT_AV_0  = 3'd1;
   localparam logic [2:0] REG_INIT_AV_1  = 3'd2;
   localparam logic [2:0] REG_INIT_AV_2  = 3'd3;
   localparam logic [2:0] REG_INIT_AV_3  = 3'd4;

   localparam logic [16:0] USED_MAX  = 17'd131071;
   localparam logic [19:0] GRANT_MAX = 20'd1048575;
   localparam logic signed [21:0] WORK_MAX = 22'sd2097151;
   localparam logic signed [21:0] WORK_MIN = -22'sd2097152;

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      WALK_START,
      WALK,
      RESPOND
   } state_type;

endpackage

// File: rtl/core/bankers_resource_allocator.sv
// banker's algorithm resource allocator with an iterative safety walk
//
// req channel carries one transaction: operation, client_id and four signed amounts.
// rsp channel returns one status per transaction. csr is an APB-style port with
// resources_in_use at 0x00 and initial_available_0..3 at 0x04..0x10.
// one transaction at a time: req_stall is high from acceptance until the status
// has been taken on rsp. init and errors found at acceptance go straight to the
// respond state; close and over-release pass through the check state first.
// a request runs the safety walk over the client table memory, one client compare
// per cycle through a registered read port; each client that finishes restarts
// the scan at client 0. an unsafe result rolls the grant back.
// reset clears the client table valid bits, granted totals and the registers
// (resources_in_use to 4, initial amounts to 0); no clearing pass is needed.
// while rsp_stall is high the status holds and no new transaction is taken.
module bankers_resource_allocator #(
   parameter int MAX_CLIENTS   = bra_pkg::MAX_CLIENTS_DEF,
   parameter int NUM_RESOURCES = bra_pkg::NUM_RESOURCES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_client_id,
   input  logic signed [15:0] req_amount_0,
   input  logic signed [15:0] req_amount_1,
   input  logic signed [15:0] req_amount_2,
   input  logic signed [15:0] req_amount_3,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import bra_pkg::*;

   localparam int CW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int SW  = CW + 1;
   localparam int CLW = NUM_RESOURCES * 16;
   localparam int UW  = NUM_RESOURCES * 17;
   localparam logic [MAX_CLIENTS-1:0] ALL_SLOTS = {MAX_CLIENTS{1'b1}};

   state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [CW-1:0] id_ff, id_in;
   logic signed [15:0] amt_ff [NUM_RESOURCES];
   logic signed [15:0] amt_in [NUM_RESOURCES];
   logic signed [15:0] req_amt [4];
   logic [MAX_CLIENTS-1:0] active_ff, active_in;
   logic [MAX_CLIENTS-1:0] finished_ff, finished_in;
   logic [19:0] granted_ff [NUM_RESOURCES];
   logic [19:0] granted_in [NUM_RESOURCES];
   logic [19:0] save_grant_ff [NUM_RESOURCES];
   logic [19:0] save_grant_in [NUM_RESOURCES];
   logic [UW-1:0] save_used_ff, save_used_in;
   logic signed [21:0] work_ff [NUM_RESOURCES];
   logic signed [21:0] work_in [NUM_RESOURCES];
   logic [SW-1:0] scan_ff, scan_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [2:0]    status_ff, status_in;
   logic [2:0]    nres_ff;
   logic [15:0]   init_av_ff [NUM_INIT_REGS];

   logic [CLW-1:0] claim_mem [MAX_CLIENTS];
   logic [UW-1:0]  used_mem [MAX_CLIENTS];
   logic [CLW-1:0] claim_rd_ff;
   logic [UW-1:0]  used_rd_ff;
   logic [CW-1:0]  rd_addr;
   logic           claim_we, used_we;
   logic [CW-1:0]  wr_addr;
   logic [CLW-1:0] claim_wd;
   logic [UW-1:0]  used_wd;

   logic [2:0] nr;
   logic       cfg_wr;
   logic [2:0] cfg_idx;

   assign req_amt[0] = req_amount_0;
   assign req_amt[1] = req_amount_1;
   assign req_amt[2] = req_amount_2;
   assign req_amt[3] = req_amount_3;

   assign nr = (32'(nres_ff) > 32'(NUM_RESOURCES)) ? 3'(NUM_RESOURCES) : nres_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[4:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         nres_ff <= 3'd4;
         for (int k = 0; k < NUM_INIT_REGS; k++) init_av_ff[k] <= '0;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_RES_IN_USE: nres_ff <= csr_pwdata[2:0];
            REG_INIT_AV_0:  init_av_ff[0] <= csr_pwdata[15:0];
            REG_INIT_AV_1:  init_av_ff[1] <= csr_pwdata[15:0];
            REG_INIT_AV_2:  init_av_ff[2] <= csr_pwdata[15:0];
            REG_INIT_AV_3:  init_av_ff[3] <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_RES_IN_USE: csr_prdata = {29'd0, nres_ff};
         REG_INIT_AV_0:  csr_prdata = {16'd0, init_av_ff[0]};
         REG_INIT_AV_1:  csr_prdata = {16'd0, init_av_ff[1]};
         REG_INIT_AV_2:  csr_prdata = {16'd0, init_av_ff[2]};
         REG_INIT_AV_3:  csr_prdata = {16'd0, init_av_ff[3]};
         default:        csr_prdata = '0;
      endcase
   end

   // client table memories
   always_ff @(posedge clock) begin
      if (claim_we) claim_mem[wr_addr] <= claim_wd;
      if (used_we) used_mem[wr_addr] <= used_wd;
      claim_rd_ff <= claim_mem[rd_addr];
      used_rd_ff  <= used_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      logic signed [18:0] u_sum;
      logic signed [21:0] g_sum;
      logic signed [18:0] need;
      logic signed [22:0] w_sum;
      logic        over_rel;
      logic        holding;
      logic        fits;
      logic [CW-1:0] req_idx;
      logic        in_range;

      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      amt_in        = amt_ff;
      active_in     = active_ff;
      finished_in   = finished_ff;
      granted_in    = granted_ff;
      save_grant_in = save_grant_ff;
      save_used_in  = save_used_ff;
      work_in       = work_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      status_in     = status_ff;
      claim_we      = 1'b0;
      used_we       = 1'b0;
      wr_addr       = id_ff;
      claim_wd      = '0;
      used_wd       = '0;
      rd_addr       = id_ff;
      req_idx       = CW'(req_client_id);
      in_range      = 32'(req_client_id) < 32'(MAX_CLIENTS);
      over_rel      = 1'b0;
      holding       = 1'b0;
      fits          = 1'b0;
      u_sum         = '0;
      g_sum         = '0;
      need          = '0;
      w_sum         = '0;

      case (state_ff)
         IDLE: begin
            rd_addr = req_idx;
            if (req_valid) begin
               op_in = req_operation;
               id_in = req_idx;
               for (int j = 0; j < NUM_RESOURCES; j++) amt_in[j] = req_amt[j];
               if (!in_range || req_operation == OP_UNKNOWN) begin
                  status_in = STS_NO_CLIENT;
                  state_in  = RESPOND;
               end else if (req_operation == OP_INIT) begin
                  if (active_ff[req_idx]) begin
                     status_in = STS_DUPLICATE;
                  end else begin
                     claim_we = 1'b1;
                     used_we  = 1'b1;
                     wr_addr  = req_idx;
                     for (int j = 0; j < NUM_RESOURCES; j++)
                        claim_wd[j*16 +: 16] = req_amt[j];
                     active_in[req_idx] = 1'b1;
                     status_in = STS_ACK;
                  end
                  state_in = RESPOND;
               end else if (!active_ff[req_idx]) begin
                  status_in = STS_NO_CLIENT;
                  state_in  = RESPOND;
               end else begin
                  state_in = CHECK;
               end
            end
         end
         CHECK: begin
            if (op_ff == OP_CLOSE) begin
               for (int j = 0; j < NUM_RESOURCES; j++)
                  if (used_rd_ff[j*17 +: 17] != '0) holding = 1'b1;
               if (holding) begin
                  status_in = STS_HOLDING;
               end else begin
                  active_in[id_ff] = 1'b0;
                  status_in = STS_ACK;
               end
               state_in = RESPOND;
            end else begin
               for (int j = 0; j < NUM_RESOURCES; j++) begin
                  u_sum = $signed({2'b00, used_rd_ff[j*17 +: 17]}) + 19'(amt_ff[j]);
                  if (3'(j) < nr && amt_ff[j] < 0 && u_sum < 0) over_rel = 1'b1;
               end
               if (over_rel) begin
                  status_in = STS_OVER_REL;
                  state_in  = RESPOND;
               end else begin
                  save_used_in  = used_rd_ff;
                  save_grant_in = granted_ff;
                  used_we = 1'b1;
                  used_wd = used_rd_ff;
                  for (int j = 0; j < NUM_RESOURCES; j++) begin
                     if (3'(j) < nr) begin
                        u_sum = $signed({2'b00, used_rd_ff[j*17 +: 17]}) + 19'(amt_ff[j]);
                        if (u_sum < 0) used_wd[j*17 +: 17] = '0;
                        else if (u_sum > $signed({2'b00, USED_MAX}))
                           used_wd[j*17 +: 17] = USED_MAX;
                        else used_wd[j*17 +: 17] = u_sum[16:0];
                        g_sum = $signed({2'b00, granted_ff[j]}) + 22'(amt_ff[j]);
                        if (g_sum < 0) granted_in[j] = '0;
                        else if (g_sum > $signed({2'b00, GRANT_MAX})) granted_in[j] = GRANT_MAX;
                        else granted_in[j] = g_sum[19:0];
                     end
                  end
                  state_in = WALK_START;
               end
            end
         end
         WALK_START: begin
            for (int j = 0; j < NUM_RESOURCES; j++)
               work_in[j] = $signed({6'd0, init_av_ff[j]}) - $signed({2'b00, granted_ff[j]});
            finished_in = ~active_ff;
            scan_in     = '0;
            cmp_vld_in  = 1'b0;
            state_in    = WALK;
         end
         WALK: begin
            rd_addr = scan_ff[CW-1:0];
            if (cmp_vld_ff && !finished_ff[cmp_idx_ff]) begin
               fits = 1'b1;
               for (int j = 0; j < NUM_RESOURCES; j++) begin
                  need = 19'($signed(claim_rd_ff[j*16 +: 16]))
                       - $signed({2'b00, used_rd_ff[j*17 +: 17]});
                  if (3'(j) < nr && 22'(need) > work_ff[j]) fits = 1'b0;
               end
            end
            if (fits) begin
               for (int j = 0; j < NUM_RESOURCES; j++) begin
                  if (3'(j) < nr) begin
                     w_sum = 23'(work_ff[j]) + $signed({6'd0, used_rd_ff[j*17 +: 17]});
                     if (w_sum > 23'(WORK_MAX)) work_in[j] = WORK_MAX;
                     else if (w_sum < 23'(WORK_MIN)) work_in[j] = WORK_MIN;
                     else work_in[j] = w_sum[21:0];
                  end
               end
               finished_in[cmp_idx_ff] = 1'b1;
               scan_in    = '0;
               cmp_vld_in = 1'b0;
               if (finished_in == ALL_SLOTS) begin
                  status_in = STS_ACK;
                  state_in  = RESPOND;
               end
            end else if (cmp_vld_ff && 32'(cmp_idx_ff) == 32'(MAX_CLIENTS - 1)) begin
               if (finished_ff == ALL_SLOTS) begin
                  status_in = STS_ACK;
               end else begin
                  used_we = 1'b1;
                  used_wd = save_used_ff;
                  granted_in = save_grant_ff;
                  status_in  = STS_WAIT;
               end
               state_in = RESPOND;
            end else if (32'(scan_ff) < 32'(MAX_CLIENTS)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[CW-1:0];
               scan_in    = scan_ff + 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         RESPOND: begin
            if (!rsp_stall) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         active_ff   <= '0;
         finished_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         for (int j = 0; j < NUM_RESOURCES; j++) granted_ff[j] <= '0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         finished_ff <= finished_in;
         cmp_vld_ff  <= cmp_vld_in;
         granted_ff  <= granted_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      amt_ff        <= amt_in;
      save_grant_ff <= save_grant_in;
      save_used_ff  <= save_used_in;
      work_ff       <= work_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      status_ff     <= status_in;
   end

   assign req_stall  = (state_ff != IDLE);
   assign rsp_valid  = (state_ff == RESPOND);
   assign rsp_status = status_ff;

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction accepted without blocking the next");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_DUPLICATE)
      else $error("status code out of range");

   a_wait_only_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_WAIT || rsp_status == STS_OVER_REL)
      |-> op_ff == OP_REQUEST)
      else $error("request status on a non-request transaction");

endmodule

// File: test/tb_top.sv
// self-checking testbench for the banker's resource allocator
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bra_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [3:0]         cid;
      logic signed [15:0] amt [4];
      bit                 drain;
   } alloc_txn_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_operation = 0;
   logic [3:0] req_client_id = 0;
   logic signed [15:0] req_amount_0 = 0, req_amount_1 = 0, req_amount_2 = 0, req_amount_3 = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bankers_resource_allocator u_top (.*);

   always #6 clock = ~clock;

   // predictor state
   int unsigned res_count;
   int unsigned init_avail [4];
   bit          active [16];
   int          claim [16][4];
   int unsigned holding [16][4];
   int unsigned granted [4];

   alloc_txn_type pending_q [$];
   logic [2:0]  status_q [$];
   int          errors = 0;
   bit          stim_done = 0;
   bit          sender_hold = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit walk_is_safe(int unsigned nr);
      longint work [4];
      bit done [16];
      int found;
      bit fits;
      for (int j = 0; j < nr; j++)
         work[j] = clip(longint'(init_avail[j]) - longint'(granted[j]), -2097152, 2097151);
      for (int i = 0; i < 16; i++) done[i] = !active[i];
      forever begin
         found = -1;
         for (int i = 0; i < 16 && found < 0; i++) begin
            if (done[i]) continue;
            fits = 1;
            for (int j = 0; j < nr; j++)
               if (longint'(claim[i][j]) - longint'(holding[i][j]) > work[j]) fits = 0;
            if (fits) found = i;
         end
         if (found < 0) break;
         for (int j = 0; j < nr; j++)
            work[j] = clip(work[j] + longint'(holding[found][j]), -2097152, 2097151);
         done[found] = 1;
      end
      foreach (done[i]) if (!done[i]) return 0;
      return 1;
   endfunction

   function automatic logic [2:0] predict_status(alloc_txn_type t);
      int unsigned nr;
      int unsigned sv_hold [4];
      int unsigned sv_grant [4];
      nr = res_count > 4 ? 4 : res_count;
      if (t.op == OP_UNKNOWN) return STS_NO_CLIENT;
      if (t.op == OP_INIT) begin
         if (active[t.cid]) return STS_DUPLICATE;
         for (int j = 0; j < 4; j++) begin
            claim[t.cid][j] = t.amt[j];
            holding[t.cid][j] = 0;
         end
         active[t.cid] = 1;
         return STS_ACK;
      end
      if (!active[t.cid]) return STS_NO_CLIENT;
      if (t.op == OP_CLOSE) begin
         for (int j = 0; j < 4; j++) if (holding[t.cid][j] != 0) return STS_HOLDING;
         active[t.cid] = 0;
         return STS_ACK;
      end
      for (int j = 0; j < nr; j++)
         if (t.amt[j] < 0 && longint'(holding[t.cid][j]) + t.amt[j] < 0) return STS_OVER_REL;
      for (int j = 0; j < 4; j++) begin
         sv_hold[j] = holding[t.cid][j];
         sv_grant[j] = granted[j];
      end
      for (int j = 0; j < nr; j++) begin
         holding[t.cid][j] = clip(longint'(holding[t.cid][j]) + t.amt[j], 0, 131071);
         granted[j] = clip(longint'(granted[j]) + t.amt[j], 0, 1048575);
      end
      if (walk_is_safe(nr)) return STS_ACK;
      for (int j = 0; j < 4; j++) begin
         holding[t.cid][j] = sv_hold[j];
         granted[j] = sv_grant[j];
      end
      return STS_WAIT;
   endfunction

   // driver
   int gap = 0;
   alloc_txn_type cur_txn;
   logic acc_now = 0;

   always @(posedge clock) begin
      acc_now <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         status_q.push_back(predict_status(cur_txn));
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !acc_now) begin
            // hold payload
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 0;
         end else if (sender_hold || pending_q.size() == 0) begin
            req_valid <= 0;
         end else if (pending_q[0].drain && status_q.size() != 0) begin
            req_valid <= 0;
         end else begin
            cur_txn = pending_q.pop_front();
            req_valid <= 1;
            req_operation <= cur_txn.op;
            req_client_id <= cur_txn.cid;
            req_amount_0 <= cur_txn.amt[0];
            req_amount_1 <= cur_txn.amt[1];
            req_amount_2 <= cur_txn.amt[2];
            req_amount_3 <= cur_txn.amt[3];
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                   : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
         end
      end
   end

   // monitor
   logic [2:0] exp_status;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            $error("status transaction with none expected: %0d", rsp_status);
            errors++;
         end else begin
            exp_status = status_q.pop_front();
            if (rsp_status !== exp_status) begin
               $error("status: expected %0d actual %0d", exp_status, rsp_status);
               errors++;
            end
         end
      end
   end

   int stall_len = 0;
   always @(negedge clock) begin
      if (stall_len > 0) begin
         stall_len <= stall_len - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_len <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                      : $urandom_range(0, 3);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == REG_RES_IN_USE) res_count = val & 7;
      else init_avail[idx - 1] = val & 16'hFFFF;
   endtask

   task automatic add_txn(logic [1:0] op, logic [3:0] cid, int a0, int a1, int a2, int a3,
                          bit drain = 0);
      alloc_txn_type t;
      t.op = op; t.cid = cid; t.drain = drain;
      t.amt[0] = 16'(a0); t.amt[1] = 16'(a1); t.amt[2] = 16'(a2); t.amt[3] = 16'(a3);
      pending_q.push_back(t);
   endtask

   function automatic int rand_amt(int hi);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 65535) - 32768;
         1: return -$urandom_range(0, hi);
         2: return 32767;
         3: return -32768;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_q.size() != 0 || status_q.size() != 0 || req_valid) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int n, int hi, int nclients);
      logic [1:0] op;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1: op = OP_INIT;
            8: op = OP_CLOSE;
            9: op = 2'($urandom_range(0, 3));
            default: op = OP_REQUEST;
         endcase
         if (op == OP_CLOSE && $urandom_range(0, 1)) begin
            logic [3:0] c;
            c = 4'($urandom_range(0, nclients - 1));
            add_txn(OP_REQUEST, c, -$urandom_range(0, hi), -$urandom_range(0, hi),
                    -$urandom_range(0, hi), -$urandom_range(0, hi));
         end
         add_txn(op, 4'($urandom_range(0, nclients - 1)), rand_amt(hi), rand_amt(hi),
                 rand_amt(hi), rand_amt(hi));
      end
   endtask

   initial begin
      res_count = 4;
      foreach (init_avail[j]) init_avail[j] = 0;
      foreach (active[i]) active[i] = 0;
      foreach (granted[j]) granted[j] = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed
      csr_write(REG_RES_IN_USE, 4);
      csr_write(REG_INIT_AV_0, 10);
      csr_write(REG_INIT_AV_1, 65535);
      csr_write(REG_INIT_AV_2, 0);
      csr_write(REG_INIT_AV_3, 5);
      add_txn(OP_REQUEST, 3, 1, 0, 0, 0);
      add_txn(OP_CLOSE, 3, 0, 0, 0, 0);
      add_txn(OP_UNKNOWN, 3, 0, 0, 0, 0);
      add_txn(OP_INIT, 0, 8, 32767, 0, 5);
      add_txn(OP_INIT, 0, 1, 1, 1, 1);
      add_txn(OP_INIT, 15, 10, -32768, 0, 2);
      add_txn(OP_REQUEST, 0, 5, 100, 0, 3);
      add_txn(OP_REQUEST, 15, 5, 0, 0, 2);
      add_txn(OP_REQUEST, 0, -6, 0, 0, 0);
      add_txn(OP_REQUEST, 0, 32767, 0, 0, 0);
      add_txn(OP_CLOSE, 0, 0, 0, 0, 0);
      add_txn(OP_REQUEST, 0, -5, -100, 0, -3);
      add_txn(OP_REQUEST, 15, -32768, 0, 0, 0);
      add_txn(OP_REQUEST, 15, 0, 0, 1, 0);
      add_txn(OP_CLOSE, 0, 0, 0, 0, 0);
      add_txn(OP_CLOSE, 15, 0, 0, 0, 0, 1);
      add_txn(OP_INIT, 7, -1, -1, -1, -1);
      add_txn(OP_REQUEST, 7, 32767, 32767, 0, 0);
      add_txn(OP_REQUEST, 7, 32767, 32767, 0, 0);
      add_txn(OP_REQUEST, 7, 32767, 32767, 0, 0);
      add_txn(OP_REQUEST, 7, 32767, 32767, 0, 0);
      add_txn(OP_REQUEST, 7, 32767, 32767, 0, 0);
      wait_idle();
      sender_hold = 1;
      for (int i = 0; i < 16; i++) begin
         if (active[i])
            for (int j = 0; j < 4; j++) if (holding[i][j] > 0) begin
               int unsigned h;
               h = holding[i][j];
               while (h > 0) begin
                  int d;
                  d = h > 32768 ? 32768 : h;
                  add_txn(OP_REQUEST, 4'(i), j == 0 ? -d : 0, j == 1 ? -d : 0,
                          j == 2 ? -d : 0, j == 3 ? -d : 0);
                  h -= d;
               end
            end
      end
      sender_hold = 0;
      wait_idle();

      // random phases across register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: csr_write(REG_RES_IN_USE, 4);
            1: csr_write(REG_RES_IN_USE, 1);
            2: csr_write(REG_RES_IN_USE, 7);
            3: csr_write(REG_RES_IN_USE, 0);
            default: csr_write(REG_RES_IN_USE, $urandom_range(2, 3));
         endcase
         for (int j = 0; j < 4; j++)
            csr_write(3'(REG_INIT_AV_0 + j),
                      ph == 2 ? 65535 : (ph == 3 ? 0 : $urandom_range(0, 40)));
         random_phase(100, ph == 2 ? 20000 : 15, ph == 1 ? 16 : $urandom_range(4, 16));
         add_txn(OP_CLOSE, 0, 0, 0, 0, 0, 1);
         wait_idle();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      repeat (400) @(posedge clock);
      if (errors == 0 && status_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #(12ns * 2000000);
      $display("CHECK FAILED");
      $finish;
   end
endmodule
